@@ sv/swbd_pkg.sv @@
// Shared types, constants and the microcode program of the sparse weight block decoder.
package swbd_pkg;

	// Block length cap: largest block the decoder handles, and results per byte.
	localparam int MAX_BLOCK    = 16;
	localparam int RESULT_LIMIT = 16;
	localparam logic [4:0] BLK_CAP = 5'((MAX_BLOCK < RESULT_LIMIT) ? MAX_BLOCK : RESULT_LIMIT);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CHANNEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OUTCH   = 3'd7;

	// Channel position may run one bit past 16 before it is wrapped.
	localparam int POS_W = 17;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'(POS_W);

	// Decoder phase, one-hot.
	typedef enum logic [3:0] {
		PH_DELTA  = 4'b0001,
		PH_MARK   = 4'b0010,
		PH_FIRST  = 4'b0100,
		PH_SECOND = 4'b1000
	} phase_t;

	// Datapath operations.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_ADD_DELTA,
		OP_DIV_CH,
		OP_DIV_COL,
		OP_DIV_ROW,
		OP_DIV_WAIT,
		OP_SET_CH,
		OP_SET_COL,
		OP_SET_ROW,
		OP_SPLIT_NEXT,
		OP_PH_MARK,
		OP_PH_DELTA,
		OP_MARK_SETUP,
		OP_EMIT_PAD_MID,
		OP_EMIT_W1,
		OP_EMIT_W2,
		OP_EMIT_PAD_END,
		OP_ADD_B,
		OP_ADD_BM1,
		OP_SECOND_END
	} op_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_PH_DELTA,
		C_PH_MARK,
		C_PH_FIRST,
		C_BYTE_ZERO,
		C_SREM_ZERO,
		C_INC_LT_SREM,
		C_INC_LT_B,
		C_SLOT_GE_B,
		C_QUO_ZERO
	} cond_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	typedef struct packed {
		logic hold;
		logic ph_delta;
		logic ph_mark;
		logic ph_first;
		logic byte_zero;
		logic srem_zero;
		logic inc_lt_srem;
		logic inc_lt_b;
		logic slot_ge_b;
		logic quo_zero;
	} stat_t;

	// Effective configuration, limits already forced to at least one.
	typedef struct packed {
		logic [15:0] cc;
		logic [7:0]  kw;
		logic [7:0]  kh;
		logic [4:0]  blk;
	} cfg_eff_t;

	typedef struct packed {
		logic        ld_ch;
		logic        ld_col;
		logic        ld_row;
		logic        ld_outch;
		logic [15:0] value;
	} pos_ld_t;

	// Program addresses.
	localparam upc_t A_IDLE        = 5'd0;
	localparam upc_t A_DISP_MARK   = 5'd1;
	localparam upc_t A_DISP_FIRST  = 5'd2;
	localparam upc_t A_DISP_SECOND = 5'd3;
	localparam upc_t A_DELTA       = 5'd4;
	localparam upc_t A_WRAP        = 5'd5;
	localparam upc_t A_WAIT_CH     = 5'd6;
	localparam upc_t A_SET_CH      = 5'd7;
	localparam upc_t A_DIV_COL     = 5'd8;
	localparam upc_t A_WAIT_COL    = 5'd9;
	localparam upc_t A_SET_COL     = 5'd10;
	localparam upc_t A_DIV_ROW     = 5'd11;
	localparam upc_t A_WAIT_ROW    = 5'd12;
	localparam upc_t A_SET_ROW     = 5'd13;
	localparam upc_t A_WEND        = 5'd14;
	localparam upc_t A_SPLIT_NEXT  = 5'd15;
	localparam upc_t A_DEND        = 5'd16;
	localparam upc_t A_MARK        = 5'd17;
	localparam upc_t A_MARK_SETUP  = 5'd18;
	localparam upc_t A_PAD_CHECK   = 5'd19;
	localparam upc_t A_PAD1        = 5'd20;
	localparam upc_t A_FIRST       = 5'd21;
	localparam upc_t A_SPLIT_CHECK = 5'd22;
	localparam upc_t A_ADD_B       = 5'd23;
	localparam upc_t A_NOSPLIT     = 5'd24;
	localparam upc_t A_SKIP        = 5'd25;
	localparam upc_t A_SECOND      = 5'd26;
	localparam upc_t A_PAD2_CHECK  = 5'd27;
	localparam upc_t A_PAD2        = 5'd28;
	localparam upc_t A_SFIN        = 5'd29;

	// Microcode: jump to target when the condition holds, else fall through.
	function automatic ctrl_t ucode_word(upc_t a);
		ctrl_t w;
		case (a)
			A_IDLE:        w = '{OP_ACCEPT,       C_PH_DELTA,    A_DELTA};
			A_DISP_MARK:   w = '{OP_NOP,          C_PH_MARK,     A_MARK};
			A_DISP_FIRST:  w = '{OP_NOP,          C_PH_FIRST,    A_FIRST};
			A_DISP_SECOND: w = '{OP_NOP,          C_ALWAYS,      A_SECOND};
			A_DELTA:       w = '{OP_ADD_DELTA,    C_NEVER,       A_IDLE};
			A_WRAP:        w = '{OP_DIV_CH,       C_NEVER,       A_IDLE};
			A_WAIT_CH:     w = '{OP_DIV_WAIT,     C_NEVER,       A_IDLE};
			A_SET_CH:      w = '{OP_SET_CH,       C_QUO_ZERO,    A_WEND};
			A_DIV_COL:     w = '{OP_DIV_COL,      C_NEVER,       A_IDLE};
			A_WAIT_COL:    w = '{OP_DIV_WAIT,     C_NEVER,       A_IDLE};
			A_SET_COL:     w = '{OP_SET_COL,      C_QUO_ZERO,    A_WEND};
			A_DIV_ROW:     w = '{OP_DIV_ROW,      C_NEVER,       A_IDLE};
			A_WAIT_ROW:    w = '{OP_DIV_WAIT,     C_NEVER,       A_IDLE};
			A_SET_ROW:     w = '{OP_SET_ROW,      C_NEVER,       A_IDLE};
			A_WEND:        w = '{OP_NOP,          C_PH_DELTA,    A_DEND};
			A_SPLIT_NEXT:  w = '{OP_SPLIT_NEXT,   C_ALWAYS,      A_IDLE};
			A_DEND:        w = '{OP_PH_MARK,      C_ALWAYS,      A_IDLE};
			A_MARK:        w = '{OP_NOP,          C_BYTE_ZERO,   A_SKIP};
			A_MARK_SETUP:  w = '{OP_MARK_SETUP,   C_NEVER,       A_IDLE};
			A_PAD_CHECK:   w = '{OP_NOP,          C_SREM_ZERO,   A_FIRST};
			A_PAD1:        w = '{OP_EMIT_PAD_MID, C_INC_LT_SREM, A_PAD1};
			A_FIRST:       w = '{OP_EMIT_W1,      C_INC_LT_B,    A_IDLE};
			A_SPLIT_CHECK: w = '{OP_NOP,          C_SREM_ZERO,   A_NOSPLIT};
			A_ADD_B:       w = '{OP_ADD_B,        C_ALWAYS,      A_WRAP};
			A_NOSPLIT:     w = '{OP_ADD_BM1,      C_ALWAYS,      A_IDLE};
			A_SKIP:        w = '{OP_PH_DELTA,     C_ALWAYS,      A_IDLE};
			A_SECOND:      w = '{OP_EMIT_W2,      C_INC_LT_SREM, A_IDLE};
			A_PAD2_CHECK:  w = '{OP_NOP,          C_SLOT_GE_B,   A_SFIN};
			A_PAD2:        w = '{OP_EMIT_PAD_END, C_INC_LT_B,    A_PAD2};
			A_SFIN:        w = '{OP_SECOND_END,   C_ALWAYS,      A_IDLE};
			default:       w = '{OP_NOP,          C_ALWAYS,      A_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/swbd_if.sv @@
// Channel interfaces of the sparse weight block decoder: byte stream, records, configuration.
interface swbd_stream_if import swbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [7:0] stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

interface swbd_rec_if import swbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [15:0]       out_channel;
	logic [7:0]        kernel_row;
	logic [7:0]        kernel_col;
	logic [15:0]       base_channel;
	logic [3:0]        slot;
	logic signed [7:0] weight;
	logic              last;

	modport source(output valid, output out_channel, output kernel_row, output kernel_col,
		output base_channel, output slot, output weight, output last, input ready);
	modport sink(input valid, input out_channel, input kernel_row, input kernel_col,
		input base_channel, input slot, input weight, input last, output ready);
endinterface

interface swbd_cfg_if import swbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/swbd_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the position wraparound.
module swbd_div import swbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [POS_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic             busy,
	output logic [POS_W-1:0] quo,
	output logic [15:0]      rem
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     q_q;
	logic [15:0]          r_q;
	logic [15:0]          d_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {r_q, q_q[POS_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[15:0] : trial[15:0];
			q_q <= {q_q[POS_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

@@ sv/swbd_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
module swbd_seq import swbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	upc_t upc_q;
	logic take;

	assign ctrl = ucode_word(upc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_PH_DELTA:    take = stat.ph_delta;
			C_PH_MARK:     take = stat.ph_mark;
			C_PH_FIRST:    take = stat.ph_first;
			C_BYTE_ZERO:   take = stat.byte_zero;
			C_SREM_ZERO:   take = stat.srem_zero;
			C_INC_LT_SREM: take = stat.inc_lt_srem;
			C_INC_LT_B:    take = stat.inc_lt_b;
			C_SLOT_GE_B:   take = stat.slot_ge_b;
			C_QUO_ZERO:    take = stat.quo_zero;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_IDLE;
		end else if (!stat.hold) begin
			upc_q <= take ? ctrl.target : upc_q + UPC_W'(1);
		end
	end

endmodule

@@ sv/swbd_dpath.sv @@
// Datapath: position and record registers, shared divider, result register.
module swbd_dpath import swbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl,
	input  cfg_eff_t      eff,
	input  pos_ld_t       pos_ld,
	output stat_t         stat,
	swbd_stream_if.sink   stream,
	swbd_rec_if.source    records
);

	phase_t           phase_q;
	logic [POS_W-1:0] pos_ch_q;
	logic [7:0]       pos_col_q;
	logic [7:0]       pos_row_q;
	logic [15:0]      pos_outch_q;
	logic [15:0]      base_q;
	logic [4:0]       slot_q;
	logic [4:0]       srem_q;
	logic [7:0]       byte_q;

	logic              out_v_q;
	logic [15:0]       rec_outch_q;
	logic [7:0]        rec_row_q;
	logic [7:0]        rec_col_q;
	logic [15:0]       rec_base_q;
	logic [3:0]        rec_slot_q;
	logic signed [7:0] rec_weight_q;
	logic              rec_last_q;

	logic             div_start;
	logic [POS_W-1:0] div_dividend;
	logic [15:0]      div_divisor;
	logic             div_busy;
	logic [POS_W-1:0] div_quo;
	logic [15:0]      div_rem;

	logic        is_emit;
	logic        hold;
	logic        fire;
	logic [5:0]  slot_inc;
	logic        inc_lt_srem;
	logic        inc_lt_b;
	logic        last_bit;

	logic        pos_in;
	logic [15:0] p16;
	logic [16:0] psum;
	logic        fits;
	logic [16:0] over;
	logic [15:0] cc_mb;

	swbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = pos_ch_q;
		div_divisor  = eff.cc;
		case (ctrl.op)
			OP_DIV_CH: begin
				div_start = 1'b1;
			end
			OP_DIV_COL: begin
				div_start    = 1'b1;
				div_dividend = {9'd0, pos_col_q} + div_quo;
				div_divisor  = {8'd0, eff.kw};
			end
			OP_DIV_ROW: begin
				div_start    = 1'b1;
				div_dividend = {9'd0, pos_row_q} + div_quo;
				div_divisor  = {8'd0, eff.kh};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign slot_inc    = {1'b0, slot_q} + 6'd1;
	assign inc_lt_srem = slot_inc < {1'b0, srem_q};
	assign inc_lt_b    = slot_inc < {1'b0, eff.blk};

	assign is_emit = (ctrl.op == OP_EMIT_PAD_MID) || (ctrl.op == OP_EMIT_W1) ||
		(ctrl.op == OP_EMIT_W2) || (ctrl.op == OP_EMIT_PAD_END);

	assign hold = ((ctrl.op == OP_ACCEPT) && !stream.valid) ||
		((ctrl.op == OP_DIV_WAIT) && div_busy) ||
		(is_emit && out_v_q && !records.ready);
	assign fire = !hold;

	always_comb begin
		case (ctrl.op)
			OP_EMIT_W1:      last_bit = 1'b1;
			OP_EMIT_W2:      last_bit = inc_lt_srem || !inc_lt_b;
			OP_EMIT_PAD_END: last_bit = !inc_lt_b;
			default:         last_bit = 1'b0;
		endcase
	end

	// split decision: a position past the limit counts as the last channel
	assign pos_in = pos_ch_q < {1'b0, eff.cc};
	assign p16    = pos_in ? pos_ch_q[15:0] : eff.cc - 16'd1;
	assign psum   = {1'b0, p16} + {12'd0, eff.blk};
	assign fits   = psum <= {1'b0, eff.cc};
	assign over   = psum - {1'b0, eff.cc};
	assign cc_mb  = eff.cc - {11'd0, eff.blk};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DELTA;
			pos_ch_q    <= '0;
			pos_col_q   <= '0;
			pos_row_q   <= '0;
			pos_outch_q <= '0;
			base_q      <= '0;
			slot_q      <= '0;
			srem_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (records.ready) begin
				out_v_q <= 1'b0;
			end
			if (fire) begin
				case (ctrl.op)
					OP_ADD_DELTA: begin
						pos_ch_q <= pos_ch_q + {9'd0, byte_q ^ 8'h80};
					end
					OP_SET_CH: begin
						pos_ch_q <= {1'b0, div_rem};
					end
					OP_SET_COL: begin
						pos_col_q <= div_rem[7:0];
					end
					OP_SET_ROW: begin
						pos_row_q   <= div_rem[7:0];
						pos_outch_q <= pos_outch_q + div_quo[15:0];
					end
					OP_SPLIT_NEXT: begin
						base_q  <= pos_ch_q[15:0];
						slot_q  <= '0;
						phase_q <= PH_SECOND;
					end
					OP_PH_MARK: begin
						phase_q <= PH_MARK;
					end
					OP_PH_DELTA: begin
						phase_q <= PH_DELTA;
					end
					OP_MARK_SETUP: begin
						slot_q  <= '0;
						phase_q <= PH_FIRST;
						if (fits) begin
							base_q <= pos_ch_q[15:0];
							srem_q <= '0;
						end else begin
							srem_q   <= over[4:0];
							pos_ch_q <= {1'b0, cc_mb};
							base_q   <= cc_mb;
						end
					end
					OP_EMIT_PAD_MID, OP_EMIT_W1, OP_EMIT_W2, OP_EMIT_PAD_END: begin
						slot_q  <= slot_inc[4:0];
						out_v_q <= 1'b1;
					end
					OP_ADD_B: begin
						pos_ch_q <= pos_ch_q + {12'd0, eff.blk};
					end
					OP_ADD_BM1: begin
						pos_ch_q <= pos_ch_q + {12'd0, eff.blk} - POS_W'(1);
						phase_q  <= PH_DELTA;
					end
					OP_SECOND_END: begin
						pos_ch_q <= {1'b0, pos_ch_q[15:0] + {11'd0, srem_q} - 16'd1};
						phase_q  <= PH_DELTA;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
			// start registers load the position directly
			if (pos_ld.ld_ch) begin
				pos_ch_q <= {1'b0, pos_ld.value};
			end
			if (pos_ld.ld_col) begin
				pos_col_q <= pos_ld.value[7:0];
			end
			if (pos_ld.ld_row) begin
				pos_row_q <= pos_ld.value[7:0];
			end
			if (pos_ld.ld_outch) begin
				pos_outch_q <= pos_ld.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_ACCEPT) && stream.valid) begin
			byte_q <= stream.stream_byte;
		end
		if (is_emit && fire) begin
			rec_outch_q  <= pos_outch_q;
			rec_row_q    <= pos_row_q;
			rec_col_q    <= pos_col_q;
			rec_base_q   <= base_q;
			rec_slot_q   <= slot_q[3:0];
			rec_weight_q <= ((ctrl.op == OP_EMIT_W1) || (ctrl.op == OP_EMIT_W2)) ?
				byte_q : 8'sd0;
			rec_last_q   <= last_bit;
		end
	end

	assign stream.ready = (ctrl.op == OP_ACCEPT);

	assign records.valid        = out_v_q;
	assign records.out_channel  = rec_outch_q;
	assign records.kernel_row   = rec_row_q;
	assign records.kernel_col   = rec_col_q;
	assign records.base_channel = rec_base_q;
	assign records.slot         = rec_slot_q;
	assign records.weight       = rec_weight_q;
	assign records.last         = rec_last_q;

	assign stat.hold        = hold;
	assign stat.ph_delta    = (phase_q == PH_DELTA);
	assign stat.ph_mark     = (phase_q == PH_MARK);
	assign stat.ph_first    = (phase_q == PH_FIRST);
	assign stat.byte_zero   = (byte_q == 8'd0);
	assign stat.srem_zero   = (srem_q == 5'd0);
	assign stat.inc_lt_srem = inc_lt_srem;
	assign stat.inc_lt_b    = inc_lt_b;
	assign stat.slot_ge_b   = slot_q >= eff.blk;
	assign stat.quo_zero    = (div_quo == '0);

endmodule

@@ sv/sparse_weight_block_decoder.sv @@
// Top level of the sparse weight block decoder: configuration registers, sequencer, datapath.
//
// Usage: encoded weight bytes enter one per beat on the stream channel; decoded
// records leave on the records channel, one beat per weight or padding slot, with
// last set on the final record that a byte causes. The user must write registers
// through the cfg channel (always ready) only while the decoder is idle; the block
// does not enforce this. Writing a start register moves the current position to that value.
// Timing is set by a microcoded sequencer and one shared divider:
//   marker or in-block weight byte: the dispatch steps, plus one emit step per record;
//   delta byte: one division without carry, three when the carry runs through
//   column and row;
//   a split block adds one to three divisions for the wrap to the next column.
// A byte is taken only when the sequencer is back at its dispatch step, so one
// byte is in work at a time. Records sit in a single output register; while the
// receiver stalls, the sequencer holds on the emit step and the stream waits.
// Reset (arst_n low, asynchronous) restores the register defaults, puts the
// position at zero and makes the next byte a delta byte.
module sparse_weight_block_decoder import swbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	swbd_cfg_if.sink    cfg,
	swbd_stream_if.sink stream,
	swbd_rec_if.source  records
);

	logic [15:0] cc_q;
	logic [7:0]  kw_q;
	logic [7:0]  kh_q;
	logic [4:0]  blen_q;

	cfg_eff_t eff;
	pos_ld_t  pos_ld;
	ctrl_t    ctrl;
	stat_t    stat;
	logic     wr;
	logic [4:0] b0;
	logic [4:0] b1;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= 16'd1;
			kw_q   <= 8'd1;
			kh_q   <= 8'd1;
			blen_q <= 5'd1;
		end else if (wr) begin
			case (cfg.index)
				CFG_CHANNEL_COUNT: cc_q   <= cfg.data;
				CFG_KERNEL_WIDTH:  kw_q   <= cfg.data[7:0];
				CFG_KERNEL_HEIGHT: kh_q   <= cfg.data[7:0];
				CFG_BLOCK_LEN:     blen_q <= cfg.data[4:0];
				default:           cc_q   <= cc_q;
			endcase
		end
	end

	// zero limits act as one; block length clipped to the cap and to the channel count
	always_comb begin
		eff.cc = (cc_q == 16'd0) ? 16'd1 : cc_q;
		eff.kw = (kw_q == 8'd0) ? 8'd1 : kw_q;
		eff.kh = (kh_q == 8'd0) ? 8'd1 : kh_q;
		b0 = (blen_q == 5'd0) ? 5'd1 : blen_q;
		b1 = (b0 > BLK_CAP) ? BLK_CAP : b0;
		eff.blk = ({11'd0, b1} > eff.cc) ? eff.cc[4:0] : b1;
	end

	always_comb begin
		pos_ld.ld_ch    = wr && (cfg.index == CFG_START_CHANNEL);
		pos_ld.ld_col   = wr && (cfg.index == CFG_START_COL);
		pos_ld.ld_row   = wr && (cfg.index == CFG_START_ROW);
		pos_ld.ld_outch = wr && (cfg.index == CFG_START_OUTCH);
		pos_ld.value    = cfg.data;
	end

	swbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	swbd_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.eff     (eff),
		.pos_ld  (pos_ld),
		.stat    (stat),
		.stream  (stream),
		.records (records)
	);

endmodule

@@ verif/swbd_record_checker.sv @@
// Checker for the sparse weight block decoder: tracks position state per beat and scores records.
module swbd_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	swbd_cfg_if         cfg,
	swbd_stream_if      stream,
	swbd_rec_if         records,
	input  logic        wrap_up,
	output int unsigned failures,
	output int unsigned pending,
	output int unsigned byte_count,
	output int unsigned record_count,
	output int unsigned split_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import swbd_pkg::*;

	typedef struct packed {
		logic [15:0]       out_channel;
		logic [7:0]        kernel_row;
		logic [7:0]        kernel_col;
		logic [15:0]       base_channel;
		logic [3:0]        slot;
		logic signed [7:0] weight;
		logic              last;
	} rec_t;

	// register copies
	int unsigned reg_cc, reg_kw, reg_kh, reg_blk;

	// decoder position state
	phase_t      dec_phase;
	int unsigned ch_pos, col_pos, row_pos, outch_pos;
	int unsigned rec_base, slot_cnt, split_rem;

	rec_t predicted_records[$];
	rec_t byte_recs[$];
	bit   wrapped;

	function automatic int unsigned floor_one(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic int unsigned block_size();
		int unsigned b;
		b = floor_one(reg_blk);
		if (b > BLK_CAP)
			b = BLK_CAP;
		if (b > floor_one(reg_cc))
			b = floor_one(reg_cc);
		return b;
	endfunction

	task automatic report_mismatch(input string msg);
		failures++;
		if (failures <= 20)
			$display("[%0t] %s", $time, msg);
	endtask

	// nested carry: channel -> column -> row -> output channel (16-bit)
	task automatic carry_position();
		int unsigned q;
		q = ch_pos / floor_one(reg_cc);
		ch_pos = ch_pos % floor_one(reg_cc);
		if (q != 0) begin
			col_pos += q;
			q = col_pos / floor_one(reg_kw);
			col_pos = col_pos % floor_one(reg_kw);
			if (q != 0) begin
				row_pos += q;
				q = row_pos / floor_one(reg_kh);
				row_pos = row_pos % floor_one(reg_kh);
				outch_pos = (outch_pos + q) & 32'hFFFF;
			end
		end
	endtask

	task automatic push_record(input int unsigned s, input logic [7:0] w);
		rec_t r;
		r.out_channel  = outch_pos[15:0];
		r.kernel_row   = row_pos[7:0];
		r.kernel_col   = col_pos[7:0];
		r.base_channel = rec_base[15:0];
		r.slot         = s[3:0];
		r.weight       = w;
		r.last         = 1'b0;
		byte_recs.push_back(r);
	endtask

	task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		case (idx)
			CFG_CHANNEL_COUNT: reg_cc = val;
			CFG_KERNEL_WIDTH:  reg_kw = val[7:0];
			CFG_KERNEL_HEIGHT: reg_kh = val[7:0];
			CFG_BLOCK_LEN:     reg_blk = val[4:0];
			CFG_START_CHANNEL: ch_pos = val;
			CFG_START_COL:     col_pos = val[7:0];
			CFG_START_ROW:     row_pos = val[7:0];
			CFG_START_OUTCH:   outch_pos = val;
			default: ;
		endcase
	endtask

	task automatic decode_byte(input logic [7:0] raw);
		int unsigned b, cc, p;
		b = block_size();
		cc = floor_one(reg_cc);
		byte_recs.delete();
		if (dec_phase == PH_DELTA) begin
			ch_pos += 32'(raw ^ 8'h80);
			carry_position();
			dec_phase = PH_MARK;
		end else begin
			if (dec_phase == PH_MARK) begin
				if (raw == 8'h00) begin
					dec_phase = PH_DELTA;
				end else begin
					// a position past the limit counts as the last channel
					p = (ch_pos < cc) ? ch_pos : cc - 1;
					slot_cnt = 0;
					if (p + b <= cc) begin
						rec_base = ch_pos;
						split_rem = 0;
					end else begin
						split_rem = p + b - cc;
						ch_pos = p - split_rem;
						rec_base = ch_pos;
						split_count++;
						while (slot_cnt < split_rem) begin
							push_record(slot_cnt, 8'h00);
							slot_cnt++;
						end
					end
					dec_phase = PH_FIRST;
				end
			end
			if (dec_phase == PH_FIRST) begin
				push_record(slot_cnt, raw);
				slot_cnt++;
				if (slot_cnt >= b) begin
					if (split_rem == 0) begin
						ch_pos += b - 1;
						dec_phase = PH_DELTA;
					end else begin
						ch_pos += b;
						carry_position();
						rec_base = ch_pos;
						slot_cnt = 0;
						dec_phase = PH_SECOND;
					end
				end
			end else if (dec_phase == PH_SECOND) begin
				push_record(slot_cnt, raw);
				slot_cnt++;
				if (slot_cnt >= split_rem) begin
					while (slot_cnt < b) begin
						push_record(slot_cnt, 8'h00);
						slot_cnt++;
					end
					ch_pos = (ch_pos + split_rem - 1) & 32'hFFFF;
					dec_phase = PH_DELTA;
				end
			end
		end
		if (byte_recs.size() != 0)
			byte_recs[byte_recs.size() - 1].last = 1'b1;
		foreach (byte_recs[i])
			predicted_records.push_back(byte_recs[i]);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("record %0d field %s: got %0d expected %0d",
				record_count, name, got, want));
	endtask

	task automatic check_record();
		rec_t want;
		if (predicted_records.size() == 0) begin
			report_mismatch($sformatf("record with none expected: outch %0d row %0d col %0d base %0d slot %0d weight %0d",
				records.out_channel, records.kernel_row, records.kernel_col,
				records.base_channel, records.slot, records.weight));
		end else begin
			want = predicted_records.pop_front();
			check_field("out_channel", records.out_channel, want.out_channel);
			check_field("kernel_row", 16'(records.kernel_row), 16'(want.kernel_row));
			check_field("kernel_col", 16'(records.kernel_col), 16'(want.kernel_col));
			check_field("base_channel", records.base_channel, want.base_channel);
			check_field("slot", 16'(records.slot), 16'(want.slot));
			check_field("weight", 16'(records.weight[7:0]), 16'(want.weight[7:0]));
			check_field("last", 16'(records.last), 16'(want.last));
		end
		record_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_cc = 1;
			reg_kw = 1;
			reg_kh = 1;
			reg_blk = 1;
			dec_phase = PH_DELTA;
			ch_pos = 0;
			col_pos = 0;
			row_pos = 0;
			outch_pos = 0;
			rec_base = 0;
			slot_cnt = 0;
			split_rem = 0;
			predicted_records.delete();
			wrapped = 1'b0;
			failures = 0;
			byte_count = 0;
			record_count = 0;
			split_count = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				load_register(cfg.index, cfg.data);
			if (stream.valid && stream.ready) begin
				decode_byte(stream.stream_byte);
				byte_count++;
			end
			if (records.valid && records.ready)
				check_record();
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (predicted_records.size() != 0)
					report_mismatch($sformatf("%0d expected records never arrived",
						predicted_records.size()));
			end
		end
		pending = predicted_records.size();
	end
endmodule

@@ verif/tb_sparse_weight_block_decoder.sv @@
// Testbench top for the sparse weight block decoder: clock, reset, stimulus and verdict.
module tb_sparse_weight_block_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import swbd_pkg::*;

	localparam int RESET_CYCLES   = 7;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_CYCLES   = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_BYTES    = 58;

	logic clk;
	logic arst_n;
	logic wrap_up;

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned holds_asked;
	int unsigned holds_done;
	int unsigned bytes_sent;
	int unsigned cur_cc;
	int unsigned cur_blk;
	int unsigned quiet_cycles = 0;

	int unsigned failures, pending, byte_count, record_count, split_count;

	swbd_cfg_if    cfg_bus ();
	swbd_stream_if byte_bus ();
	swbd_rec_if    rec_bus ();

	sparse_weight_block_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.stream  (byte_bus),
		.records (rec_bus)
	);

	swbd_record_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_bus),
		.stream       (byte_bus),
		.records      (rec_bus),
		.wrap_up      (wrap_up),
		.failures     (failures),
		.pending      (pending),
		.byte_count   (byte_count),
		.record_count (record_count),
		.split_count  (split_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// output side: random stalls, plus a long hold-off when asked
	initial begin
		rec_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				rec_bus.ready <= 1'b0;
				holds_done++;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rec_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_bus.valid && byte_bus.ready) || (rec_bus.valid && rec_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned weights_per_block();
		int unsigned b, cc;
		cc = (cur_cc == 0) ? 1 : cur_cc;
		b = (cur_blk == 0) ? 1 : cur_blk;
		if (b > BLK_CAP)
			b = BLK_CAP;
		if (b > cc)
			b = cc;
		return b;
	endfunction

	// valid stays up across back-to-back beats; dropped only on an idle cycle
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.stream_byte <= b;
		do @(posedge clk); while (!byte_bus.ready);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_CHANNEL_COUNT)
			cur_cc = val;
		else if (idx == CFG_BLOCK_LEN)
			cur_blk = val[4:0];
	endtask

	// stream quiet, all records in, then room for a delta still in work
	task automatic settle();
		byte_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// delta, then skip marker or a full block; now and then a short block
	task automatic send_record();
		int unsigned n;
		send_byte(8'($urandom_range(255)));
		if ($urandom_range(3) == 0) begin
			send_byte(8'h00);
		end else begin
			n = weights_per_block();
			if ($urandom_range(19) == 0)
				n = $urandom_range(n, 1);
			send_byte(8'($urandom_range(255, 1)));
			for (int unsigned i = 1; i < n; i++)
				send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int unsigned cc, kw, kh, blk, first;
		arst_n = 1'b0;
		wrap_up = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.stream_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_CHANNEL_COUNT;
		cfg_bus.data = '0;
		idle_pct = 0;
		stall_pct = 0;
		holds_asked = 0;
		holds_done = 0;
		bytes_sent = 0;
		cur_cc = 1;
		cur_blk = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full carry with outch wrap, plain block, split block, skip
		write_reg(CFG_CHANNEL_COUNT, 16'd4);
		write_reg(CFG_KERNEL_WIDTH, 16'd3);
		write_reg(CFG_KERNEL_HEIGHT, 16'd2);
		write_reg(CFG_BLOCK_LEN, 16'd3);
		write_reg(CFG_START_CHANNEL, 16'd1);
		write_reg(CFG_START_COL, 16'd2);
		write_reg(CFG_START_ROW, 16'd1);
		write_reg(CFG_START_OUTCH, 16'hFFFF);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h80);
		// position moved past channel_count while waiting for a marker
		settle();
		write_reg(CFG_START_CHANNEL, 16'd200);
		send_byte(8'h7F);
		send_byte(8'h10);
		// block length shrinks in the middle of the second half of a split
		settle();
		write_reg(CFG_BLOCK_LEN, 16'd1);
		send_byte(8'h20);
		// zero limits behave as one
		settle();
		write_reg(CFG_CHANNEL_COUNT, 16'd0);
		write_reg(CFG_KERNEL_WIDTH, 16'd0);
		write_reg(CFG_KERNEL_HEIGHT, 16'd0);
		write_reg(CFG_BLOCK_LEN, 16'd0);
		send_byte(8'h00);
		send_byte(8'hC0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 85; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 85; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			case (ph)
				0: begin cc = 2; kw = 255; kh = 255; blk = 5; end
				1: begin cc = 65535; kw = 1; kh = 1; blk = 31; end
				2: begin cc = 7; kw = 3; kh = 5; blk = 16; end
				4: begin cc = 16; kw = 4; kh = 4; blk = 16; end
				5: begin
					cc = $urandom_range(65535);
					kw = $urandom_range(255);
					kh = $urandom_range(255);
					blk = $urandom_range(31);
				end
				6: begin cc = 1; kw = 1; kh = 1; blk = 1; end
				default: begin
					cc = $urandom_range(40, 1);
					kw = $urandom_range(8, 1);
					kh = $urandom_range(8, 1);
					blk = $urandom_range(16, 1);
				end
			endcase
			write_reg(CFG_CHANNEL_COUNT, 16'(cc));
			write_reg(CFG_KERNEL_WIDTH, 16'(kw));
			write_reg(CFG_KERNEL_HEIGHT, 16'(kh));
			write_reg(CFG_BLOCK_LEN, 16'(blk));
			if (ph == 1) begin
				write_reg(CFG_START_CHANNEL, 16'hFFFF);
				write_reg(CFG_START_COL, 16'd255);
				write_reg(CFG_START_ROW, 16'd255);
				write_reg(CFG_START_OUTCH, 16'hFFFF);
			end else begin
				write_reg(CFG_START_CHANNEL, 16'($urandom_range(cc)));
				write_reg(CFG_START_COL, 16'($urandom_range(kw)));
				write_reg(CFG_START_ROW, 16'($urandom_range(kh)));
				write_reg(CFG_START_OUTCH, 16'($urandom_range(65535)));
			end
			// long output hold-off while bytes keep coming, to back up the input
			if (ph == 4)
				holds_asked++;
			first = bytes_sent;
			while (bytes_sent - first < PHASE_BYTES) begin
				if ($urandom_range(99) < 12)
					send_byte(8'($urandom_range(255)));
				else
					send_record();
			end
		end

		settle();
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Covered %0d stream bytes and %0d records (%0d split blocks) over %0d settings,",
			byte_count, record_count, split_count, PHASES + 4);
		$display("with sender gaps, receiver stalls and one long output hold-off.");
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ sim.f @@
sv/swbd_pkg.sv
sv/swbd_if.sv
sv/swbd_div.sv
sv/swbd_seq.sv
sv/swbd_dpath.sv
sv/sparse_weight_block_decoder.sv
verif/swbd_record_checker.sv
verif/tb_sparse_weight_block_decoder.sv
